[sv/routing_table_coordination_engine_assert.svh]
// Assertion macros for the routing table coordination engine.
// Included by the top level; needs only a clock and an active-low reset.
`ifndef ROUTING_TABLE_COORDINATION_ENGINE_ASSERT_SVH
`define ROUTING_TABLE_COORDINATION_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define RTCE_ASSERT_IMP(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RTCE_ASSERT_NXT(label, ck, rstn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rtce_pkg.sv]
// Types and constants of the routing table coordination engine.
// No dependencies; imported by the top level.
package rtce_pkg;

	localparam logic [9:0] UNREACH     = 10'd999;
	localparam logic [4:0] NO_SLOT     = 5'd16;
	localparam logic [4:0] MAX_RESULTS = 5'd17;

	// Input event codes
	localparam logic [1:0] FN_ADVERT    = 2'd0;
	localparam logic [1:0] FN_QUERY     = 2'd1;
	localparam logic [1:0] FN_REPLY     = 2'd2;
	localparam logic [1:0] FN_LINK_FAIL = 2'd3;

	// Outgoing message kinds
	localparam logic [1:0] MK_ANNOUNCE = 2'd0;
	localparam logic [1:0] MK_QUERY    = 2'd1;
	localparam logic [1:0] MK_REPLY    = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_REPLY,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// One route entry as stored in the table memory
	typedef struct packed {
		logic [9:0]  cost;
		logic [4:0]  next_hop;
		logic        coord;
		logic [4:0]  succ;
		logic [15:0] pending;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		cost:     UNREACH,
		next_hop: NO_SLOT,
		coord:    1'b0,
		succ:     NO_SLOT,
		pending:  16'd0
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] mask;
		logic [3:0]  dest;
		logic [9:0]  cost;
	} msg_t;

	function automatic msg_t mk_msg(logic [1:0] kind, logic [15:0] mask, logic [3:0] dest,
		logic [9:0] cost);
		msg_t m;
		m.kind = kind;
		m.mask = mask;
		m.dest = dest;
		m.cost = cost;
		return m;
	endfunction

endpackage

[sv/routing_table_coordination_engine.sv]
// Routing table coordination engine: route table in one synchronous memory,
// sequenced by a read-modify-write state machine. Depends on rtce_pkg and
// routing_table_coordination_engine_assert.svh.
//
// Use: one control event enters per item on the input channel (func,
// neighbor_slot, dest_id, advertised_cost). The block answers with zero to
// NODES messages on the output channel, the final one marked by last. The
// single configuration register (open neighbor mask) is written through the
// cfg channel, which is always ready; write it only while no item is in work.
// A coordination request, an uncoordination reply or an advert that changes
// nothing passes from idle through look and flush; a request answered with a
// route and a reply adds a reply state. A link failure walks every table entry
// through the single memory read port, one entry per cycle while the output
// does not stall; an advert that installs a route reads its entry first, then
// walks the table. A new item is accepted once the previous item's final
// message sits in the output register.
// Reset clears the open neighbor mask and the entry valid flags, so every
// entry reads as unreachable, no next hop, forwarding, nothing pending.
// A stalled receiver holds the output register; the sequencer then freezes
// with one message held back, and memory accesses wait with it.
module routing_table_coordination_engine #(
	parameter int NODES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [3:0]  neighbor_slot,
	input  logic [3:0]  dest_id,
	input  logic [9:0]  advertised_cost,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  msg_kind,
	output logic [15:0] target_mask,
	output logic [3:0]  msg_dest,
	output logic [9:0]  msg_cost,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	import rtce_pkg::*;

	`include "routing_table_coordination_engine_assert.svh"

	localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam logic [AW:0]   IDX_END  = (AW + 1)'(NODES);
	localparam logic [AW-1:0] IDX_LAST = AW'(NODES - 1);

	// Sequencer state
	state_t state_q, state_d;

	// Captured item
	logic [1:0]  func_q;
	logic [3:0]  nb_q;
	logic [3:0]  dest_q;
	logic [9:0]  adv_q;

	logic [15:0] active_q;

	// Table memory and per-entry valid flags
	entry_t          mem [NODES];
	logic [NODES-1:0] vld_q;
	entry_t          rd_data_s1;
	logic            rd_vld_s1;

	// Scan pointers: rd_idx_q is the next address to read, scan_*_s1 the entry in hand
	logic [AW:0]     rd_idx_q;
	logic            scan_vld_s1;
	logic [AW-1:0]   scan_idx_s1;

	// One message is held back so that last can be set on the final one
	msg_t            held_q;
	logic            held_valid_q;
	logic [4:0]      cnt_q;

	msg_t            out_q;
	logic            out_valid_q;
	logic            out_last_q;

	// Combinational control
	entry_t          ent;
	entry_t          wr_data;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            cand_vld;
	msg_t            cand;
	logic            cand_take;
	logic            flush;
	logic            stall;
	logic            out_free;
	logic            out_load;
	logic            in_accept;
	logic            dest_ok;
	logic [15:0]     nbit;
	logic [15:0]     to_mask;
	logic [15:0]     fail_mask;
	logic [15:0]     succ_mask;
	logic [15:0]     pend_new;
	logic [10:0]     cost_sum;
	logic [9:0]      hop_cost;

	// Entries never written read as the reset route
	assign ent       = rd_vld_s1 ? rd_data_s1 : ENTRY_RESET;
	assign nbit      = 16'd1 << nb_q;
	assign to_mask   = nbit & active_q;
	assign fail_mask = active_q & ~nbit;
	assign succ_mask = ent.succ[4] ? 16'd0 : ((16'd1 << ent.succ[3:0]) & active_q);
	assign pend_new  = ent.pending & ~nbit;
	// Advertised cost plus one, saturated at unreachable
	assign cost_sum  = {1'b0, adv_q} + 11'd1;
	assign hop_cost  = (cost_sum > {1'b0, UNREACH}) ? UNREACH : cost_sum[9:0];
	assign dest_ok   = 32'(dest_id) < NODES;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cand_vld = 1'b0;
		cand     = mk_msg(MK_ANNOUNCE, 16'd0, dest_q, 10'd0);
		wr_en    = 1'b0;
		wr_addr  = AW'(dest_q);
		wr_data  = ent;
		rd_en    = 1'b0;
		rd_addr  = AW'(dest_id);
		flush    = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (func == FN_LINK_FAIL) begin
						state_d = ST_SCAN;
					end else if (dest_ok) begin
						rd_en   = 1'b1;
						state_d = ST_LOOK;
					end
				end
			end

			ST_LOOK: begin
				case (func_q)
					FN_ADVERT: begin
						// Install a cheaper route; leave coordination silently
						if (hop_cost < ent.cost) begin
							wr_en            = 1'b1;
							wr_data.cost     = hop_cost;
							wr_data.next_hop = {1'b0, nb_q};
							if (ent.coord) begin
								wr_data.coord = 1'b0;
								wr_data.succ  = NO_SLOT;
							end
							state_d = ST_SCAN;
						end else begin
							state_d = ST_FLUSH;
						end
					end
					FN_QUERY: begin
						if (ent.coord) begin
							cand_vld = (to_mask != 16'd0);
							cand     = mk_msg(MK_REPLY, to_mask, dest_q, 10'd0);
							state_d  = ST_FLUSH;
						end else if (ent.next_hop != {1'b0, nb_q}) begin
							// Answer with our route, then the reply
							cand_vld = (to_mask != 16'd0);
							cand     = mk_msg(MK_ANNOUNCE, to_mask, dest_q, ent.cost);
							state_d  = ST_REPLY;
						end else begin
							// Our next hop asks: enter coordination, query all open slots.
							// With no open slot it ends at once and the reply goes nowhere.
							wr_en            = 1'b1;
							wr_data.cost     = UNREACH;
							wr_data.next_hop = NO_SLOT;
							wr_data.coord    = (active_q != 16'd0);
							wr_data.succ     = (active_q != 16'd0) ? {1'b0, nb_q} : NO_SLOT;
							wr_data.pending  = active_q;
							cand_vld         = (active_q != 16'd0);
							cand             = mk_msg(MK_QUERY, active_q, dest_q, 10'd0);
							state_d          = ST_FLUSH;
						end
					end
					FN_REPLY: begin
						// Clear the pending bit; end coordination when nothing open waits.
						// A coordinating route is always unreachable, so no announcement.
						wr_en           = 1'b1;
						wr_data.pending = pend_new;
						if (ent.coord && ((pend_new & active_q) == 16'd0)) begin
							wr_data.coord = 1'b0;
							wr_data.succ  = NO_SLOT;
							cand_vld      = (succ_mask != 16'd0);
							cand          = mk_msg(MK_REPLY, succ_mask, dest_q, 10'd0);
						end
						state_d = ST_FLUSH;
					end
					default: begin
						state_d = ST_FLUSH;
					end
				endcase
			end

			ST_REPLY: begin
				cand_vld = (to_mask != 16'd0);
				cand     = mk_msg(MK_REPLY, to_mask, dest_q, 10'd0);
				state_d  = ST_FLUSH;
			end

			ST_SCAN: begin
				rd_addr = rd_idx_q[AW-1:0];
				rd_en   = (rd_idx_q != IDX_END);
				wr_addr = scan_idx_s1;
				if (scan_vld_s1) begin
					if (func_q == FN_ADVERT) begin
						// Re-announce every finite forwarding route
						if (!ent.coord && (ent.cost < UNREACH)) begin
							cand_vld = (active_q != 16'd0);
							cand     = mk_msg(MK_ANNOUNCE, active_q, 4'(scan_idx_s1), ent.cost);
						end
					end else begin
						// Link failure: routes over that slot enter coordination.
						// A coordinating entry never has a next hop, so only
						// forwarding entries match.
						if (ent.next_hop == {1'b0, nb_q}) begin
							wr_en            = 1'b1;
							wr_data.cost     = UNREACH;
							wr_data.next_hop = NO_SLOT;
							wr_data.coord    = (fail_mask != 16'd0);
							wr_data.succ     = NO_SLOT;
							wr_data.pending  = fail_mask;
							cand_vld         = (fail_mask != 16'd0);
							cand             = mk_msg(MK_QUERY, fail_mask, 4'(scan_idx_s1), 10'd0);
						end
					end
					if (scan_idx_s1 == IDX_LAST) begin
						state_d = ST_FLUSH;
					end
				end
			end

			ST_FLUSH: begin
				flush   = 1'b1;
				state_d = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Results past the limit are dropped; state updates still happen
		cand_take = cand_vld && (cnt_q != MAX_RESULTS);
		stall     = held_valid_q && !out_free && (cand_take || flush);
		out_load  = held_valid_q && out_free && (cand_take || flush);

		// Freeze everything while the output side is full
		if (stall) begin
			state_d = state_q;
			wr_en   = 1'b0;
			rd_en   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Captured item fields
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_q <= func;
			nb_q   <= neighbor_slot;
			dest_q <= dest_id;
			adv_q  <= advertised_cost;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			active_q <= cfg_data;
		end
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// Scan pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			scan_vld_s1 <= 1'b0;
			scan_idx_s1 <= '0;
		end else if (in_accept) begin
			rd_idx_q    <= '0;
			scan_vld_s1 <= 1'b0;
		end else if (state_q == ST_LOOK) begin
			rd_idx_q    <= '0;
			scan_vld_s1 <= 1'b0;
		end else if (state_q == ST_SCAN && !stall) begin
			scan_vld_s1 <= rd_en;
			scan_idx_s1 <= rd_idx_q[AW-1:0];
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	// Held message and result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			cnt_q        <= '0;
		end else if (in_accept) begin
			cnt_q <= '0;
		end else if (!stall) begin
			if (cand_take) begin
				held_valid_q <= 1'b1;
				cnt_q        <= cnt_q + 1'b1;
			end else if (flush) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cand_take && !stall) begin
			held_q <= cand;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q      <= held_q;
			out_last_q <= flush;
		end
	end

	assign out_valid   = out_valid_q;
	assign msg_kind    = out_q.kind;
	assign target_mask = out_q.mask;
	assign msg_dest    = out_q.dest;
	assign msg_cost    = out_q.cost;
	assign last        = out_last_q;

	`RTCE_ASSERT_IMP(a_idle_drained, clk, arst_n, in_ready, !held_valid_q && !scan_vld_s1, "item accepted with a message still held")
	`RTCE_ASSERT_IMP(a_coord_unreach, clk, arst_n, wr_en && wr_data.coord, (wr_data.cost == UNREACH) && (wr_data.next_hop == NO_SLOT), "coordinating entry written with a route")
	`RTCE_ASSERT_NXT(a_stall_freeze, clk, arst_n, stall, $stable(state_q) && $stable(held_q), "sequencer moved during an output stall")
	`RTCE_ASSERT_IMP(a_cnt_cap, clk, arst_n, held_valid_q, (cnt_q != 5'd0) && (cnt_q <= MAX_RESULTS), "result count out of range")

endmodule
